### hdl/sbms_pkg.sv
// Package for the sparse byte memory store: field widths, command and status codes.
// No dependencies; imported by sparse_byte_memory_store_core.
package sbms_pkg;

  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SLOT_W   = ADDR_W + BYTE_W;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_UNINIT = 2'd1,
    STATUS_FULL   = 2'd2
  } status_e;

endpackage

### hdl/sparse_byte_memory_store_core.sv
// Sparse byte memory store: slot table scanned one entry per cycle by a small sequencer.
// Depends on sbms_pkg.
//
// channel  | signals                          | payload
// ---------+----------------------------------+------------------------------------------
// request  | s_axis_tvalid/tready/tdata/tuser | tdata[63:0] address, [71:64] write_data;
//          |                                  | tuser cmd (0 read, 1 write)
// response | m_axis_tvalid/tready/tdata/tuser | tdata[7:0] read_data; tuser[1:0] status
//
// A miss scans every used slot (one slot read per cycle, compare one behind) and ends at once
// on an empty table; a hit in slot k stops the scan there. The response shows the next cycle, and
// the next request can be taken in the cycle after it leaves.
// Reset clears the used count and the sequencer; slot contents are not reset.
// The block takes one request at a time: s_axis_tready is high only while idle,
// and a response waits in its register until m_axis_tready is seen.
module sparse_byte_memory_store_core #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // [63:0] address, [71:64] write_data
  input  logic [sbms_pkg::SLOT_W-1:0]               s_axis_tdata,
  // [0] cmd
  input  logic                                      s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // [7:0] read_data
  output logic [sbms_pkg::BYTE_W-1:0]               m_axis_tdata,
  // [1:0] status
  output logic [sbms_pkg::STATUS_W-1:0]             m_axis_tuser
);
  import sbms_pkg::*;

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(NUM_SLOTS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(NUM_SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     used_q, used_d;
  logic [CntW-1:0]     idx_q, idx_d;
  logic [IdxW-1:0]     rd_idx_q, rd_idx_d;
  logic                rd_vld_q, rd_vld_d;
  cmd_e                cmd_q, cmd_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [BYTE_W-1:0]   wbyte_q, wbyte_d;
  logic [BYTE_W-1:0]   rdata_q, rdata_d;
  status_e             status_q, status_d;

  logic [SLOT_W-1:0]   slot_mem_q [NUM_SLOTS];
  logic [SLOT_W-1:0]   rd_data_q;
  logic                mem_re, mem_we;
  logic [IdxW-1:0]     mem_raddr, mem_waddr;
  logic [SLOT_W-1:0]   mem_wdata;

  logic                issue, hit;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = rdata_q;
  assign m_axis_tuser  = status_q;

  // slot word: address in the upper bits, byte in the lower
  assign issue = (idx_q < used_q);
  assign hit   = rd_vld_q && (rd_data_q[SLOT_W-1:BYTE_W] == addr_q);

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    idx_d     = idx_q;
    rd_idx_d  = rd_idx_q;
    rd_vld_d  = rd_vld_q;
    cmd_d     = cmd_q;
    addr_d    = addr_q;
    wbyte_d   = wbyte_q;
    rdata_d   = rdata_q;
    status_d  = status_q;
    mem_re    = 1'b0;
    mem_raddr = idx_q[IdxW-1:0];
    mem_we    = 1'b0;
    mem_waddr = rd_idx_q;
    mem_wdata = {addr_q, wbyte_q};

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d    = cmd_e'(s_axis_tuser);
          addr_d   = s_axis_tdata[ADDR_W-1:0];
          wbyte_d  = s_axis_tdata[SLOT_W-1:ADDR_W];
          idx_d    = '0;
          rd_vld_d = 1'b0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_d  = ST_OUT;
          rd_vld_d = 1'b0;
          status_d = STATUS_OK;
          if (cmd_q == CMD_WRITE) begin
            mem_we  = 1'b1;
            rdata_d = '0;
          end else begin
            rdata_d = rd_data_q[BYTE_W-1:0];
          end
        end else if (!issue && !rd_vld_q) begin
          // scanned every used slot without a match
          state_d = ST_OUT;
          rdata_d = '0;
          if (cmd_q == CMD_WRITE) begin
            if (used_q < CntMax) begin
              mem_we    = 1'b1;
              mem_waddr = used_q[IdxW-1:0];
              used_d    = used_q + CntW'(1);
              status_d  = STATUS_OK;
            end else begin
              status_d = STATUS_FULL;
            end
          end else begin
            status_d = STATUS_UNINIT;
          end
        end else begin
          rd_vld_d = issue;
          if (issue) begin
            mem_re   = 1'b1;
            rd_idx_d = idx_q[IdxW-1:0];
            idx_d    = idx_q + CntW'(1);
          end
        end
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      used_q   <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      idx_q    <= idx_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    cmd_q    <= cmd_d;
    addr_q   <= addr_d;
    wbyte_q  <= wbyte_d;
    rdata_q  <= rdata_d;
    status_q <= status_d;
  end

  // slot table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= slot_mem_q[mem_raddr];
    end
  end

endmodule
